### sv/chtm_pkg.sv
package chtm_pkg;

  localparam int unsigned TblBits  = 20;
  localparam int unsigned TblLen   = 24;
  localparam int unsigned Prescale = 8;
  localparam int unsigned AngW     = 30;
  localparam int unsigned VecW     = 28;

  localparam logic [AngW-1:0] Deg180 = AngW'(180) << TblBits;
  localparam logic [AngW-1:0] Deg360 = AngW'(360) << TblBits;

  function automatic logic [AngW-1:0] atan_lookup(input logic [4:0] idx);
    logic [AngW-1:0] r;
    case (idx)
      5'd0:  r = AngW'(47185920);
      5'd1:  r = AngW'(27855475);
      5'd2:  r = AngW'(14718068);
      5'd3:  r = AngW'(7471121);
      5'd4:  r = AngW'(3750058);
      5'd5:  r = AngW'(1876857);
      5'd6:  r = AngW'(938658);
      5'd7:  r = AngW'(469357);
      5'd8:  r = AngW'(234682);
      5'd9:  r = AngW'(117342);
      5'd10: r = AngW'(58671);
      5'd11: r = AngW'(29335);
      5'd12: r = AngW'(14668);
      5'd13: r = AngW'(7334);
      5'd14: r = AngW'(3667);
      5'd15: r = AngW'(1833);
      5'd16: r = AngW'(917);
      5'd17: r = AngW'(458);
      5'd18: r = AngW'(229);
      5'd19: r = AngW'(115);
      5'd20: r = AngW'(57);
      5'd21: r = AngW'(29);
      5'd22: r = AngW'(14);
      5'd23: r = AngW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/chtm_cordic.sv
module chtm_cordic
  import chtm_pkg::*;
#(
  parameter int unsigned Steps    = 16,
  parameter int unsigned FracBits = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [15:0]          x_i,
  input  logic signed [15:0]          y_i,
  output logic                        done_o,
  output logic [FracBits+8:0]         heading_o
);

  localparam int unsigned RunSteps = (Steps < TblLen) ? Steps : TblLen;
  localparam int unsigned Shift    = TblBits - FracBits;
  localparam int unsigned HW       = FracBits + 9;
  localparam logic [HW-1:0] Full   = HW'(360) << FracBits;

  typedef enum logic [1:0] {IDLE, ITER, FINISH} state_e;

  state_e state_q;
  logic [4:0] step_q;
  logic signed [VecW-1:0] x_q, y_q;
  logic [AngW-1:0] z_q;
  logic zero_q;
  logic [HW-1:0] heading_q;
  logic done_q;

  logic signed [VecW-1:0] dx, dy, x0, y0;
  logic [AngW-1:0] zw, zr;
  logic [HW:0] hr;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign x0 = VecW'(x_i) <<< Prescale;
  assign y0 = VecW'(y_i) <<< Prescale;

  always_comb begin
    zw = z_q;
    if (zw[AngW-1]) begin
      zw = zw + Deg360;
    end else if (zw >= Deg360) begin
      zw = zw - Deg360;
    end
    zr = zw + (AngW'(1) << (Shift - 1));
    hr = (HW+1)'(zr >> Shift);
    if (hr >= {1'b0, Full}) begin
      hr = hr - {1'b0, Full};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            step_q  <= '0;
            zero_q  <= (x_i == 16'sd0) && (y_i == 16'sd0);
            if (x_i < 0) begin
              x_q <= -x0;
              y_q <= -y0;
              z_q <= Deg180;
            end else begin
              x_q <= x0;
              y_q <= y0;
              z_q <= '0;
            end
            state_q <= ITER;
          end
        end
        ITER: begin
          if (!y_q[VecW-1]) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + atan_lookup(step_q);
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - atan_lookup(step_q);
          end
          step_q <= step_q + 5'd1;
          if (step_q == 5'(RunSteps - 1)) begin
            state_q <= FINISH;
          end
        end
        FINISH: begin
          heading_q <= zero_q ? '0 : hr[HW-1:0];
          done_q    <= 1'b1;
          state_q   <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign done_o    = done_q;
  assign heading_o = heading_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> heading_q < Full) else $error("heading out of range");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ITER |-> step_q < 5'(RunSteps)) else $error("step overrun");

endmodule

### sv/chtm_window.sv
module chtm_window
  import chtm_pkg::*;
#(
  parameter int unsigned Window   = 5,
  parameter int unsigned FracBits = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FracBits+8:0]   value_i,
  output logic                  done_o,
  output logic                  avg_valid_o,
  output logic [8:0]            avg_o
);

  localparam int unsigned HW = FracBits + 9;
  localparam int unsigned IW = $clog2(Window);
  localparam int unsigned CW = $clog2(Window + 1);
  localparam int unsigned SW = HW + CW;
  localparam int unsigned BW = $clog2(SW);

  typedef enum logic [2:0] {IDLE, MINMAX, SUM, DIV, OUT} state_e;

  state_e state_q;
  logic [HW-1:0] win_q [Window];
  logic [CW-1:0] fill_q;
  logic [IW-1:0] idx_q;
  logic [HW-1:0] mn_q, mx_q;
  logic [SW-1:0] sum_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] quo_q;
  logic [BW-1:0] bit_q;
  logic done_q, valid_q;
  logic [8:0] avg_q;
  logic [HW-1:0] cur;
  logic [SW:0] trial;
  logic [SW-1:0] rem_sh;

  assign cur    = win_q[idx_q];
  assign rem_sh = rem_q;
  assign trial  = {1'b0, rem_sh} - ((SW+1)'(cnt_q) << bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
      avg_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            win_q[fill_q[IW-1:0]] <= value_i;
            if (fill_q == CW'(Window - 1)) begin
              fill_q  <= '0;
              idx_q   <= '0;
              mn_q    <= '1;
              mx_q    <= '0;
              state_q <= MINMAX;
            end else begin
              fill_q  <= fill_q + CW'(1);
              valid_q <= 1'b0;
              avg_q   <= '0;
              done_q  <= 1'b1;
            end
          end
        end
        MINMAX: begin
          if (cur < mn_q) mn_q <= cur;
          if (cur > mx_q) mx_q <= cur;
          if (idx_q == IW'(Window - 1)) begin
            idx_q   <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= SUM;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        SUM: begin
          if (cur != mn_q && cur != mx_q) begin
            sum_q <= sum_q + SW'(cur);
            cnt_q <= cnt_q + CW'(1);
          end
          if (idx_q == IW'(Window - 1)) begin
            state_q <= DIV;
            bit_q   <= BW'(HW);
            quo_q   <= '0;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        DIV: begin
          if (cnt_q == '0) begin
            quo_q   <= SW'((({1'b0, mn_q}) + ({1'b0, mx_q})) >> 1);
            state_q <= OUT;
          end else begin
            if (bit_q == BW'(HW)) begin
              rem_q <= sum_q;
            end
            if (bit_q == BW'(HW) ? 1'b0 : !trial[SW]) begin
              rem_q        <= trial[SW-1:0];
              quo_q[bit_q] <= 1'b1;
            end
            if (bit_q == '0) begin
              state_q <= OUT;
            end else if (bit_q == BW'(HW)) begin
              bit_q <= BW'(HW - 1);
            end else begin
              bit_q <= bit_q - 1'b1;
            end
          end
        end
        OUT: begin
          avg_q   <= 9'(quo_q >> FracBits);
          valid_q <= 1'b1;
          done_q  <= 1'b1;
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign done_o      = done_q;
  assign avg_valid_o = valid_q;
  assign avg_o       = avg_q;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CW'(Window)) else $error("fill overrun");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !valid_q |-> avg_q == '0) else $error("avg not cleared");
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");

endmodule

### sv/compass_heading_trimmed_mean_core.sv
// Compass heading core with a trimmed-mean window.
// Input channel: in_valid_i / in_stall_o carry one word of mag_x_i and mag_y_i.
// Output channel: out_valid_o / out_stall_i carry one result word per input:
// heading_o (degrees * 2^ANGLE_FRAC_BITS), sector_o, average_valid_o and
// average_degrees_o.
// Each word runs a CORDIC of min(CORDIC_STEPS, 24) iterations in one shared
// add/shift unit, plus a setup step and a rounding step.
// Every WINDOW_SIZE-th word then adds a window pass: a min/max scan, a sum of
// the headings other than the minimum and maximum, and a restoring divide.
// One word is in work at a time: the next word is taken only after the
// current one has finished its window step.
// The result waits in an output register while the next word is processed.
// The input is stalled while a word is in work, and a word whose heading is
// ready while the receiver still holds the previous result waits before its
// window step.
// Reset clears the control state and the window fill count; stored headings
// are only read after being written in the current window.
module compass_heading_trimmed_mean_core
  import chtm_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE     = 5,
  parameter int unsigned ANGLE_FRAC_BITS = 6,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           mag_x_i,
  input  logic signed [15:0]           mag_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ANGLE_FRAC_BITS+8:0]   heading_o,
  output logic [2:0]                   sector_o,
  output logic                         average_valid_o,
  output logic [8:0]                   average_degrees_o
);

  localparam int unsigned HW = ANGLE_FRAC_BITS + 9;
  localparam logic [HW-1:0] Sect45 = HW'(45) << ANGLE_FRAC_BITS;

  logic busy_q, out_valid_q, pend_q;
  logic cordic_done, win_done, win_valid;
  logic [HW-1:0] hdg, heading_q;
  logic [8:0] win_avg, avg_q;
  logic avg_valid_q;
  logic [2:0] sector_q, sect;
  logic accept, out_free, win_start;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign win_start  = (cordic_done || pend_q) && out_free;

  always_comb begin
    sect = 3'd7;
    for (int k = 7; k >= 1; k--) begin
      if (hdg < HW'(k) * Sect45) sect = 3'(k - 1);
    end
  end

  chtm_cordic #(.Steps(CORDIC_STEPS), .FracBits(ANGLE_FRAC_BITS)) u_cordic (
    .clk_i, .rst_ni, .start_i(accept), .x_i(mag_x_i), .y_i(mag_y_i),
    .done_o(cordic_done), .heading_o(hdg)
  );

  chtm_window #(.Window(WINDOW_SIZE), .FracBits(ANGLE_FRAC_BITS)) u_window (
    .clk_i, .rst_ni, .start_i(win_start), .value_i(hdg),
    .done_o(win_done), .avg_valid_o(win_valid), .avg_o(win_avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (win_start) begin
        pend_q <= 1'b0;
      end else if (cordic_done) begin
        pend_q <= 1'b1;
      end
      if (win_done) begin
        out_valid_q <= 1'b1;
        busy_q      <= 1'b0;
        heading_q   <= hdg;
        sector_q    <= sect;
        avg_valid_q <= win_valid;
        avg_q       <= win_avg;
      end else begin
        if (accept) busy_q <= 1'b1;
        if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign heading_o         = heading_q;
  assign sector_o          = sector_q;
  assign average_valid_o   = avg_valid_q;
  assign average_degrees_o = avg_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done |-> !out_valid_q) else $error("result overwritten");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept) else $error("accept while busy");
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> sector_q <= 3'd7 && heading_q < HW'(360) << ANGLE_FRAC_BITS)
    else $error("bad result");

endmodule

### bench/tb_compass_heading_trimmed_mean_core.sv
`timescale 1ns / 100ps

module tb_compass_heading_trimmed_mean_core;

  localparam int unsigned WinSize  = 5;
  localparam int unsigned FracBits = 6;
  localparam int unsigned Steps    = 16;
  localparam int unsigned RandItems = 1250;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } sample_t;

  typedef struct packed {
    logic [14:0] heading;
    logic [2:0]  sector;
    logic        avg_valid;
    logic [8:0]  avg_deg;
  } compass_word_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] mag_x, mag_y;
  logic out_valid, out_stall;
  logic [14:0] heading;
  logic [2:0] sector;
  logic avg_valid;
  logic [8:0] avg_deg;

  compass_heading_trimmed_mean_core #(
    .WINDOW_SIZE(WinSize), .ANGLE_FRAC_BITS(FracBits), .CORDIC_STEPS(Steps)
  ) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mag_x_i(mag_x), .mag_y_i(mag_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .heading_o(heading), .sector_o(sector),
    .average_valid_o(avg_valid), .average_degrees_o(avg_deg)
  );

  sample_t pending_samples[$];
  compass_word_t expected_words[$];
  logic [14:0] win_hist[WinSize];
  int unsigned win_count;
  int unsigned errors;
  int unsigned words_seen;
  int unsigned windows_seen;
  int unsigned burst_left, gap_left, hold_left;
  bit long_hold_done;

  function automatic longint atan_deg(int unsigned i);
    longint t[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  function automatic logic [14:0] cordic_heading(logic signed [15:0] sx,
                                                 logic signed [15:0] sy);
    longint x, y, z, dx, dy, h;
    longint full;
    int unsigned sh;
    full = longint'(360) << FracBits;
    sh = 20 - FracBits;
    x = sx;
    y = sy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180) << 20;
    end
    x = x <<< 8;
    y = y <<< 8;
    for (int unsigned i = 0; i < Steps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += atan_deg(i);
      end else begin
        x -= dx;
        y += dy;
        z -= atan_deg(i);
      end
    end
    while (z < 0) z += longint'(360) << 20;
    while (z >= (longint'(360) << 20)) z -= longint'(360) << 20;
    h = (z + (longint'(1) << (sh - 1))) >>> sh;
    if (h >= full) h -= full;
    return h[14:0];
  endfunction

  function automatic compass_word_t predict_word(sample_t s);
    compass_word_t w;
    logic [14:0] mn, mx;
    longint sum, cnt;
    int unsigned sect;
    w = '0;
    w.heading = cordic_heading(s.x, s.y);
    sect = w.heading / (45 << FracBits);
    if (sect > 7) sect = 7;
    w.sector = sect[2:0];
    if (win_count >= WinSize) win_count = 0;
    win_hist[win_count] = w.heading;
    win_count++;
    if (win_count >= WinSize) begin
      mn = win_hist[0];
      mx = win_hist[0];
      sum = 0;
      cnt = 0;
      for (int i = 1; i < WinSize; i++) begin
        if (win_hist[i] < mn) mn = win_hist[i];
        if (win_hist[i] > mx) mx = win_hist[i];
      end
      for (int i = 0; i < WinSize; i++) begin
        if (win_hist[i] != mn && win_hist[i] != mx) begin
          sum += win_hist[i];
          cnt++;
        end
      end
      if (cnt == 0) begin
        sum = (longint'(mn) + mx) / 2;
        cnt = 1;
      end
      w.avg_deg = 9'((sum / cnt) >> FracBits);
      w.avg_valid = 1'b1;
      win_count = 0;
    end
    return w;
  endfunction

  function automatic sample_t make_sample(int sx, int sy);
    sample_t s;
    s.x = 16'(sx);
    s.y = 16'(sy);
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      mag_x <= '0;
      mag_y <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_words.push_back(predict_word({mag_x, mag_y}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_valid <= 1'b1;
        {mag_x, mag_y} <= pending_samples.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        compass_word_t got, exp_w;
        got = {heading, sector, avg_valid, avg_deg};
        words_seen++;
        if (avg_valid) windows_seen++;
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.heading !== exp_w.heading) begin
            $error("heading: expected %0d, actual %0d", exp_w.heading, got.heading);
            errors++;
          end
          if (got.sector !== exp_w.sector) begin
            $error("sector: expected %0d, actual %0d", exp_w.sector, got.sector);
            errors++;
          end
          if (got.avg_valid !== exp_w.avg_valid) begin
            $error("average_valid: expected %0d, actual %0d",
                   exp_w.avg_valid, got.avg_valid);
            errors++;
          end
          if (got.avg_deg !== exp_w.avg_deg) begin
            $error("average_degrees: expected %0d, actual %0d",
                   exp_w.avg_deg, got.avg_deg);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && words_seen >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else begin
        case ((words_seen / 97) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  initial begin
    int base, spread, n;
    int directed[25][2] = '{
      '{0, 0}, '{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32768},
      '{32767, 32767}, '{-32768, -32768}, '{-32768, 32767}, '{32767, -32768},
      '{-1, 0}, '{1, 0}, '{0, 1}, '{0, -1}, '{-1, -1}, '{-1, 1},
      '{100, 100}, '{100, 100}, '{100, 100}, '{100, 100}, '{100, 100},
      '{1000, 0}, '{1000, 1}, '{1000, 0}, '{1000, 1}, '{1000, 0}};
    errors = 0;
    words_seen = 0;
    windows_seen = 0;
    win_count = 0;
    foreach (win_hist[i]) win_hist[i] = '0;
    for (int i = 0; i < 25; i++)
      pending_samples.push_back(make_sample(directed[i][0], directed[i][1]));
    pending_samples.push_back(make_sample(-1000, 1));
    n = 0;
    while (n < RandItems) begin
      case ($urandom_range(0, 3))
        0: begin
          for (int k = 0; k < 5; k++)
            pending_samples.push_back(make_sample($urandom, $urandom));
        end
        1: begin
          base = $urandom_range(0, 32767);
          spread = $urandom_range(0, 300);
          for (int k = 0; k < 5; k++)
            pending_samples.push_back(make_sample(
              $urandom_range(0, 1) ? base : -base,
              int'($urandom_range(0, 2 * spread)) - spread));
        end
        2: begin
          base = $urandom_range(1, 20);
          for (int k = 0; k < 5; k++)
            pending_samples.push_back(make_sample(
              int'($urandom_range(0, 2 * base)) - base,
              int'($urandom_range(0, 2 * base)) - base));
        end
        default: begin
          base = int'($urandom) % 32768;
          spread = int'($urandom) % 32768;
          for (int k = 0; k < 5; k++)
            pending_samples.push_back(make_sample(base, spread));
        end
      endcase
      n += 5;
    end
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_samples.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    wait (expected_words.size() == 0);
    repeat (100) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      errors++;
    end
    $display("Checked %0d result words, %0d closing a window; extremes, zero vector,",
             words_seen, windows_seen);
    $display("left half plane, equal and two-valued windows and a long output hold.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### compass_heading_trimmed_mean_core.f
sv/chtm_pkg.sv
sv/chtm_cordic.sv
sv/chtm_window.sv
sv/compass_heading_trimmed_mean_core.sv
bench/tb_compass_heading_trimmed_mean_core.sv
